// ===== rtl/core/bus_pkg.sv =====
// Block upload sender package: item types, command and state codes.
// Used by the channel interfaces and the top level; no dependencies.
package bus_pkg;

  // Frame geometry
  localparam int FrameLen   = 20;
  localparam int BlockBytes = 16;
  localparam int DataOffset = 4;
  localparam int CmpW       = 14;
  localparam logic [7:0] MarkerByte = 8'h01;
  localparam logic [3:0] RetryLimitRst = 4'd3;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_LOAD      = 3'd0,
    CMD_START     = 3'd1,
    CMD_CMD_DONE  = 3'd2,
    CMD_DATA_DONE = 3'd3,
    CMD_CONFIRM   = 3'd4,
    CMD_TICK      = 3'd5
  } cmd_e;

  // Confirm codes
  typedef enum logic [1:0] {
    CF_OK     = 2'd0,
    CF_FAIL   = 2'd1,
    CF_RESEND = 2'd2
  } confirm_e;

  // Transfer state as reported on the output
  typedef enum logic [2:0] {
    XS_IDLE     = 3'd0,
    XS_CMD_PEND = 3'd1,
    XS_CMD_SENT = 3'd2,
    XS_DAT_PEND = 3'd4,
    XS_DAT_SENT = 3'd5,
    XS_WAIT     = 3'd7
  } xfer_e;

  // Internal sequencer states
  typedef enum logic [6:0] {
    SQ_CLEAR = 7'b0000001,
    SQ_IDLE  = 7'b0000010,
    SQ_FRD   = 7'b0000100,
    SQ_FOUT  = 7'b0001000,
    SQ_MWR   = 7'b0010000,
    SQ_SRD   = 7'b0100000,
    SQ_SCHK  = 7'b1000000
  } seq_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [7:0] block_index;
    logic [1:0] confirm_code;
    logic       last_flag;
    logic       link_busy;
  } in_item_t;

  typedef struct packed {
    logic       frame_kind;
    logic [7:0] frame_byte;
    logic [4:0] byte_position;
    logic       frame_end;
    logic [2:0] transfer_state;
  } out_item_t;

endpackage

// ===== rtl/core/bus_in_if.sv =====
// Input channel of the block upload sender: valid, ready and one event item.
// Depends on bus_pkg.
interface bus_in_if;
  import bus_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/core/bus_out_if.sv =====
// Output channel of the block upload sender: valid, ready and one frame byte item.
// Depends on bus_pkg.
interface bus_out_if;
  import bus_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/core/bus_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
// No dependencies.
module bus_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/block_upload_sender.sv =====
// Block upload sender top level: event sequencer, payload store and sent-mark store.
// Depends on bus_pkg, bus_in_if, bus_out_if and bus_ram.
//
// Usage: events arrive on up_i (load byte, start, write-done, confirm, tick).
// The block takes one item at a time; up_i.ready is high only while the
// sequencer is idle. Each frame leaves on dn_o as 20 items, one per byte,
// through a single output register, each via SQ_FRD then SQ_FOUT. A start
// first clears the sent marks, then sends the command frame, or defers it
// while the link is busy. A data write-done writes the current mark, then
// scans the marks (one read of the mark memory per visited block) and sends
// the first unmarked block as the next data frame, or enters the wait state
// if none is left; every payload byte costs one read of the payload store.
// After reset the same clearing pass runs over all MAX_BLOCKS+1 marks, during
// which no item is taken; the wait retry limit resets to 3 and is written via
// cfg_we_i/cfg_wdata_i, which the user must do only while the block is idle;
// the block does not enforce this. On a dn_o stall the current byte waits in
// the output register and the sequencer holds until it is taken; no item is lost.
module block_upload_sender #(
  parameter int MAX_BLOCKS = 136
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bus_in_if.sink     up_i,
  bus_out_if.source  dn_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);
  import bus_pkg::*;

  localparam int StoreDepth = MAX_BLOCKS * BlockBytes;
  localparam int StoreAW    = $clog2(StoreDepth);
  localparam int LenW       = $clog2(StoreDepth + 1);
  localparam int MarkDepth  = MAX_BLOCKS + 1;
  localparam int MarkAW     = $clog2(MarkDepth);

  seq_e              sq_q, sq_d;
  xfer_e             xs_q, xs_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [15:0]       sum_q, sum_d;
  logic [7:0]        cb_q, cb_d;
  logic [3:0]        wc_q, wc_d;
  logic [3:0]        lim_q;
  logic              closed_q, closed_d;
  logic              busy_q, busy_d;
  logic              kind_q, kind_d;
  logic [4:0]        pos_q, pos_d;
  logic [8:0]        idx_q, idx_d;
  logic              phase_q, phase_d;
  logic [MarkAW-1:0] clr_q, clr_d;
  logic              clr_start_q, clr_start_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic               st_we, st_re;
  logic [StoreAW-1:0] st_waddr, st_raddr;
  logic [7:0]         st_wdata, st_rdata;
  logic               mk_we, mk_re, mk_wdata, mk_rdata;
  logic [MarkAW-1:0]  mk_waddr, mk_raddr;

  logic [CmpW-1:0] len_x, len2, blk_base, pos_addr;
  logic [8:0]      cnt;
  logic [3:0]      byte_ofs;
  logic            blk_ok, busy_eff, snd_cmd, snd_data;
  logic [LenW-1:0] len_b;
  logic [15:0]     sum_b;
  logic [7:0]      cmd_byte, dat_byte;

  // Memories
  bus_ram #(.Width(8), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .re_i(st_re), .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  bus_ram #(.Width(1), .Depth(MarkDepth)) u_marks (
    .clk_i, .we_i(mk_we), .waddr_i(mk_waddr), .wdata_i(mk_wdata),
    .re_i(mk_re), .raddr_i(mk_raddr), .rdata_o(mk_rdata)
  );

  // Length arithmetic and block geometry
  assign len_x    = CmpW'(len_q);
  assign len2     = len_x + CmpW'(2);
  assign cnt      = 9'((len_x + CmpW'(1)) >> 4) + 9'd1;
  assign blk_base = CmpW'({cb_q, 4'b0000});
  assign blk_ok   = blk_base <= len_x + CmpW'(1);
  assign byte_ofs = 4'(pos_q - 5'(DataOffset));
  assign pos_addr = CmpW'({cb_q, byte_ofs});
  assign len_b    = closed_q ? '0 : len_q;
  assign sum_b    = closed_q ? '0 : sum_q;
  assign busy_eff = (sq_q == SQ_IDLE) ? up_i.item.link_busy : busy_q;

  // Command frame byte
  always_comb begin
    case (pos_q)
      5'd0, 5'd1: cmd_byte = MarkerByte;
      5'd2:       cmd_byte = len2[7:0];
      5'd3:       cmd_byte = 8'(len2 >> 8);
      default:    cmd_byte = 8'h00;
    endcase
  end

  // Data frame byte: block number, zeros, then payload and checksum
  always_comb begin
    dat_byte = 8'h00;
    if (blk_ok) begin
      if (pos_q == 5'd0) begin
        dat_byte = cb_q;
      end else if (pos_q >= 5'(DataOffset)) begin
        if (pos_addr < len_x) begin
          dat_byte = st_rdata;
        end else if (pos_addr == len_x) begin
          dat_byte = sum_q[7:0];
        end else if (pos_addr == len_x + CmpW'(1)) begin
          dat_byte = sum_q[15:8];
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    sq_d = sq_q;  xs_d = xs_q;  len_d = len_q;  sum_d = sum_q;  cb_d = cb_q;
    wc_d = wc_q;  closed_d = closed_q;  busy_d = busy_q;  kind_d = kind_q;
    pos_d = pos_q;  idx_d = idx_q;  phase_d = phase_q;  clr_d = clr_q;
    clr_start_d = clr_start_q;  out_d = out_q;
    out_valid_d = out_valid_q && !dn_o.ready;
    st_we = 1'b0;  st_waddr = len_b[StoreAW-1:0];  st_wdata = up_i.item.data_byte;
    st_re = 1'b0;  st_raddr = pos_addr[StoreAW-1:0];
    mk_we = 1'b0;  mk_waddr = clr_q;  mk_wdata = 1'b0;
    mk_re = 1'b0;  mk_raddr = idx_q[MarkAW-1:0];
    snd_cmd = 1'b0;  snd_data = 1'b0;

    case (sq_q)
      SQ_CLEAR: begin
        mk_we = 1'b1;
        if (clr_q == MarkAW'(MarkDepth - 1)) begin
          clr_d = '0;
          clr_start_d = 1'b0;
          sq_d = SQ_IDLE;
          snd_cmd = clr_start_q;
        end else begin
          clr_d = clr_q + MarkAW'(1);
        end
      end
      SQ_IDLE: begin
        if (up_i.valid) begin
          busy_d = up_i.item.link_busy;
          case (up_i.item.command)
            CMD_LOAD: begin
              if (xs_q == XS_IDLE) begin
                closed_d = up_i.item.last_flag;
                len_d = len_b;
                sum_d = sum_b;
                if (CmpW'(len_b) < CmpW'(StoreDepth)) begin
                  st_we = 1'b1;
                  len_d = len_b + LenW'(1);
                  sum_d = sum_b + 16'(up_i.item.data_byte);
                end
              end
            end
            CMD_START: begin
              closed_d = 1'b1;
              xs_d = XS_CMD_PEND;
              clr_start_d = 1'b1;
              clr_d = '0;
              sq_d = SQ_CLEAR;
            end
            CMD_CMD_DONE: begin
              if (xs_q == XS_CMD_SENT) begin
                cb_d = 8'd0;
                snd_data = 1'b1;
              end
            end
            CMD_DATA_DONE: begin
              if (xs_q == XS_DAT_SENT) begin
                sq_d = SQ_MWR;
              end
            end
            CMD_CONFIRM: begin
              if (up_i.item.confirm_code == CF_OK || up_i.item.confirm_code == CF_FAIL) begin
                xs_d = XS_IDLE;
              end else if (up_i.item.confirm_code == CF_RESEND) begin
                if (9'(up_i.item.block_index) < 9'(MarkDepth)) begin
                  mk_we = 1'b1;
                  mk_waddr = up_i.item.block_index[MarkAW-1:0];
                end
                if (up_i.item.last_flag) begin
                  xs_d = XS_DAT_PEND;
                  cb_d = 8'd0;
                  snd_data = 1'b1;
                end
              end
            end
            CMD_TICK: begin
              case (xs_q)
                XS_WAIT: begin
                  if (wc_q >= lim_q) begin
                    wc_d = 4'd0;
                    xs_d = XS_IDLE;
                  end else begin
                    wc_d = wc_q + 4'd1;
                  end
                end
                XS_CMD_PEND, XS_CMD_SENT: snd_cmd = 1'b1;
                XS_DAT_PEND: snd_data = 1'b1;
                XS_DAT_SENT: sq_d = SQ_MWR;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      SQ_FRD: begin
        st_re = pos_q >= 5'(DataOffset);
        sq_d = SQ_FOUT;
      end
      SQ_FOUT: begin
        if (!out_valid_q || dn_o.ready) begin
          out_valid_d = 1'b1;
          out_d.frame_kind = kind_q;
          out_d.frame_byte = kind_q ? dat_byte : cmd_byte;
          out_d.byte_position = pos_q;
          out_d.frame_end = pos_q == 5'(FrameLen - 1);
          out_d.transfer_state = xs_q;
          if (pos_q == 5'(FrameLen - 1)) begin
            sq_d = SQ_IDLE;
          end else begin
            pos_d = pos_q + 5'd1;
            sq_d = SQ_FRD;
          end
        end
      end
      SQ_MWR: begin
        // Mark the block just sent, if it holds any data
        if (blk_ok && 9'(cb_q) < 9'(MarkDepth)) begin
          mk_we = 1'b1;
          mk_waddr = cb_q[MarkAW-1:0];
          mk_wdata = 1'b1;
        end
        phase_d = 1'b0;
        idx_d = 9'(cb_q);
        sq_d = SQ_SRD;
      end
      SQ_SRD: begin
        if (!phase_q) begin
          if (idx_q < cnt) begin
            mk_re = 1'b1;
            sq_d = SQ_SCHK;
          end else begin
            phase_d = 1'b1;
            idx_d = 9'd0;
          end
        end else if (idx_q < 9'(cb_q) && idx_q < cnt) begin
          mk_re = 1'b1;
          sq_d = SQ_SCHK;
        end else begin
          xs_d = XS_WAIT;
          sq_d = SQ_IDLE;
        end
      end
      SQ_SCHK: begin
        if (!mk_rdata) begin
          cb_d = idx_q[7:0];
          snd_data = 1'b1;
        end else begin
          idx_d = idx_q + 9'd1;
          sq_d = SQ_SRD;
        end
      end
      default: sq_d = SQ_IDLE;
    endcase

    // Frame launch: a busy link defers the frame
    if (snd_cmd && !busy_eff) begin
      xs_d = XS_CMD_SENT;
      kind_d = 1'b0;
      pos_d = 5'd0;
      sq_d = SQ_FRD;
    end
    if (snd_data) begin
      if (busy_eff) begin
        xs_d = XS_DAT_PEND;
        sq_d = SQ_IDLE;
      end else begin
        xs_d = XS_DAT_SENT;
        kind_d = 1'b1;
        pos_d = 5'd0;
        sq_d = SQ_FRD;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= SQ_CLEAR;  xs_q <= XS_IDLE;  len_q <= '0;  sum_q <= '0;
      cb_q <= '0;  wc_q <= '0;  closed_q <= 1'b0;  busy_q <= 1'b0;
      kind_q <= 1'b0;  pos_q <= '0;  idx_q <= '0;  phase_q <= 1'b0;
      clr_q <= '0;  clr_start_q <= 1'b0;  out_valid_q <= 1'b0;
      lim_q <= RetryLimitRst;
    end else begin
      sq_q <= sq_d;  xs_q <= xs_d;  len_q <= len_d;  sum_q <= sum_d;
      cb_q <= cb_d;  wc_q <= wc_d;  closed_q <= closed_d;  busy_q <= busy_d;
      kind_q <= kind_d;  pos_q <= pos_d;  idx_q <= idx_d;  phase_q <= phase_d;
      clr_q <= clr_d;  clr_start_q <= clr_start_d;  out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign up_i.ready = sq_q == SQ_IDLE;
  assign dn_o.valid = out_valid_q;
  assign dn_o.item  = out_q;

  // Checks
  a_data_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_kind |-> out_q.transfer_state == XS_DAT_SENT)
    else $error("data frame byte without data-sent state");

  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(len_q) <= CmpW'(StoreDepth))
    else $error("payload length past store depth");

  a_mark_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_q == SQ_SCHK |-> $past(mk_re))
    else $error("mark check without a prior mark read");

endmodule
